// File: rtl/core/assert_macros.svh
// shared assertion macros for the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    // character offset counter width
    localparam int OFFSET_BITS = 20;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // symbol value marking a character outside the alphabet
    localparam logic [6:0] SYM_BAD = 7'd64;
    localparam logic [7:0] CH_PAD  = 8'h3D;

    // configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_URL_ALPHABET     = 1'b0;
    localparam logic REG_PADDING_REQUIRED = 1'b1;

    // item kinds
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // error kinds
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_CHAR   = 3'd1,
        ERR_EARLY_PAD  = 3'd2,
        ERR_DATA_AFTER = 3'd3,
        ERR_LEFTOVER   = 3'd4,
        ERR_INCOMPLETE = 3'd5,
        ERR_PAD_FORBID = 3'd6
    } t_err_kind;

    // input beat
    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   byte_valid;
        logic                   error;
        logic [2:0]             error_kind;
        logic [OFFSET_BITS-1:0] error_offset;
        logic                   done_res;
    } t_out_beat;

    // decoder stream state
    typedef struct packed {
        logic [1:0]             group_pos;
        logic [1:0]             pad_cnt;
        logic [7:0]             partial;
        logic [OFFSET_BITS-1:0] char_off;
        logic                   err_lat;
        t_err_kind              err_code;
        logic [OFFSET_BITS-1:0] err_pos;
    } t_dec_state;

    // configuration seen by the step logic
    typedef struct packed {
        logic url_alphabet;
        logic padding_required;
    } t_dec_cfg;

    // character to 6-bit symbol, SYM_BAD when not in the alphabet
    function automatic logic [6:0] sym_value(input logic [7:0] c, input logic url);
        logic [6:0] v;
        v = SYM_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61) + 7'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30) + 7'd52;
        end else if (c == CH_PAD) begin
            v = 7'd0;
        end else if (url && c == 8'h2D) begin
            v = 7'd62;
        end else if (url && c == 8'h5F) begin
            v = 7'd63;
        end else if (!url && c == 8'h2B) begin
            v = 7'd62;
        end else if (!url && c == 8'h2F) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64d_step.sv
`default_nettype none

module b64d_step import b64d_pkg::*; (
    input  t_dec_cfg   i_cfg,
    input  t_in_beat   i_beat,
    input  t_dec_state i_state,
    output t_dec_state o_state,
    output t_out_beat  o_res
);

    logic [6:0]             w_sym;
    logic [5:0]             w_v;
    logic                   w_is_pad;
    logic [OFFSET_BITS-1:0] w_prev;
    logic [1:0]             w_pad_next;
    logic [7:0]             w_byte;
    logic                   w_valid;

    // symbol lookup and previous-character offset
    always_comb begin
        w_sym    = sym_value(i_beat.ch, i_cfg.url_alphabet);
        w_v      = w_sym[5:0];
        w_is_pad = (i_beat.ch == CH_PAD);
        if (i_state.char_off == OFFSET_MAX) begin
            w_prev = i_state.char_off;
        end else if (i_state.char_off != '0) begin
            w_prev = i_state.char_off - OFFSET_BITS'(1);
        end else begin
            w_prev = '0;
        end
        w_pad_next = w_is_pad ? i_state.pad_cnt + 2'd1 : i_state.pad_cnt;
    end

    // one step of the stream state
    always_comb begin
        o_state = i_state;
        w_byte  = '0;
        w_valid = 1'b0;
        if (i_beat.action == ACT_CHAR) begin
            if (i_state.char_off != OFFSET_MAX) begin
                o_state.char_off = i_state.char_off + OFFSET_BITS'(1);
            end
            if (!i_state.err_lat) begin
                priority if (w_sym == SYM_BAD) begin
                    o_state.err_lat  = 1'b1;
                    o_state.err_code = ERR_BAD_CHAR;
                    o_state.err_pos  = i_state.char_off;
                end else if (w_is_pad && !i_state.group_pos[1]) begin
                    o_state.err_lat  = 1'b1;
                    o_state.err_code = ERR_EARLY_PAD;
                    o_state.err_pos  = i_state.char_off;
                end else if (!w_is_pad && i_state.pad_cnt != 2'd0) begin
                    o_state.err_lat  = 1'b1;
                    o_state.err_code = ERR_DATA_AFTER;
                    o_state.err_pos  = w_prev;
                end else if (w_is_pad && i_state.partial != 8'd0) begin
                    o_state.err_lat  = 1'b1;
                    o_state.err_code = ERR_LEFTOVER;
                    o_state.err_pos  = w_prev;
                end else begin
                    o_state.pad_cnt = w_pad_next;
                    // place the six symbol bits by group position
                    unique case (i_state.group_pos)
                        2'd0: begin
                            o_state.partial   = {w_v, 2'b00};
                            o_state.group_pos = 2'd1;
                        end
                        2'd1: begin
                            w_byte            = i_state.partial | {6'd0, w_v[5:4]};
                            w_valid           = 1'b1;
                            o_state.partial   = {w_v[3:0], 4'd0};
                            o_state.group_pos = 2'd2;
                        end
                        2'd2: begin
                            w_byte            = i_state.partial | {4'd0, w_v[5:2]};
                            w_valid           = (w_pad_next == 2'd0);
                            o_state.partial   = {w_v[1:0], 6'd0};
                            o_state.group_pos = 2'd3;
                        end
                        default: begin
                            w_byte            = i_state.partial | {2'd0, w_v};
                            w_valid           = (w_pad_next == 2'd0);
                            o_state.partial   = 8'd0;
                            o_state.group_pos = 2'd0;
                        end
                    endcase
                end
            end
        end else if (!i_state.err_lat) begin
            // end of stream rules
            if (i_cfg.padding_required) begin
                if (i_state.group_pos != 2'd0) begin
                    o_state.err_lat  = 1'b1;
                    o_state.err_code = ERR_INCOMPLETE;
                    o_state.err_pos  = i_state.char_off;
                end
            end else if (i_state.pad_cnt != 2'd0) begin
                o_state.err_lat  = 1'b1;
                o_state.err_code = ERR_PAD_FORBID;
                o_state.err_pos  = i_state.char_off;
            end
        end
    end

    // result beat from the updated state
    always_comb begin
        o_res.out_byte     = w_valid ? w_byte : 8'd0;
        o_res.byte_valid   = w_valid;
        o_res.error        = o_state.err_lat;
        o_res.error_kind   = o_state.err_lat ? o_state.err_code : ERR_NONE;
        o_res.error_offset = o_state.err_lat ? o_state.err_pos : '0;
        o_res.done_res     = i_beat.action;
    end

endmodule

`default_nettype wire

// File: rtl/core/base64_stream_decoder_top.sv
`default_nettype none

// Base64 stream decoder, one character beat in and one result beat out per cycle
// while the output is not stalled. A beat taken at the input lands in an input
// register; the step logic then updates the stream state and loads the result
// register once the result register is free or not stalled, so a new beat can be
// taken every cycle while the output is not stalled; output stall backs up through
// the input register. Registers at byte address 0 (url alphabet) and 4 (padding
// required) are written over the APB-style port; the user must write them only
// while the decoder is idle, which the block itself does not enforce.

`include "assert_macros.svh"

module base64_stream_decoder_top import b64d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       r_url, n_url;
    logic       r_pad_req, n_pad_req;
    logic       r_in_vld, n_in_vld;
    t_in_beat   r_in_beat;
    logic       r_out_vld, n_out_vld;
    t_out_beat  r_out_beat;
    t_dec_state r_state;
    t_dec_state w_state_next;
    t_out_beat  w_res;
    t_dec_cfg   w_cfg;
    logic       w_advance;
    logic       w_in_acc;
    logic       w_cfg_wr;

    // handshake control
    assign w_advance   = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_advance;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_url     = r_url;
        n_pad_req = r_pad_req;
        if (w_cfg_wr) begin
            unique case (paddr[CFG_ADDR_W-1])
                REG_URL_ALPHABET:     n_url     = pwdata[0];
                REG_PADDING_REQUIRED: n_pad_req = pwdata[0];
                default:              n_url     = r_url;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[CFG_ADDR_W-1])
                REG_URL_ALPHABET:     prdata = {31'd0, r_url};
                REG_PADDING_REQUIRED: prdata = {31'd0, r_pad_req};
                default:              prdata = '0;
            endcase
        end
    end

    // valid flags of the two stages
    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_acc) begin
            n_in_vld = 1'b1;
        end else if (w_advance) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (w_advance) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    assign w_cfg.url_alphabet     = r_url;
    assign w_cfg.padding_required = r_pad_req;

    // per-character decode step
    b64d_step u_step (
        .i_cfg   (w_cfg),
        .i_beat  (r_in_beat),
        .i_state (r_state),
        .o_state (w_state_next),
        .o_res   (w_res)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url     <= 1'b0;
            r_pad_req <= 1'b1;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            r_url     <= n_url;
            r_pad_req <= n_pad_req;
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (w_advance) begin
                r_state <= w_state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_beat <= i_in_beat;
        end
        if (w_advance) begin
            r_out_beat <= w_res;
        end
    end

    // checks
    `ASSERT_NEXT(a_err_sticky, r_state.err_lat, r_state.err_lat, "error latch cleared")
    `ASSERT_IMPL(a_byte_clean, o_out_valid && o_out_beat.byte_valid,
        !o_out_beat.error && !o_out_beat.done_res, "byte on error or end beat")
    `ASSERT_IMPL(a_kind_match, o_out_valid,
        o_out_beat.error == (o_out_beat.error_kind != ERR_NONE), "error flag and kind disagree")
    `ASSERT_IMPL(a_group_start, r_state.group_pos == 2'd0, r_state.partial == 8'd0,
        "partial bits left at group start")

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import b64d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned IDLE_PCT    = 38;

    // directed rows either carry a beat or write a register
    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_SET_URL,
        ROW_SET_PADREQ
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       action;
        logic [7:0] ch;
        logic       cfg_val;
        logic       typed;
        t_out_beat  want;
    } t_dir_row;

    // beat waiting to be driven, with its typed result if it has one
    typedef struct {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_tx_entry;

    localparam t_out_beat NO_RES = '0;
    localparam t_out_beat END_OK = '{
        out_byte: 8'h00, byte_valid: 1'b0, error: 1'b0,
        error_kind: ERR_NONE, error_offset: '0, done_res: 1'b1
    };

    localparam t_dir_row DIRECTED_TAB [26] = '{
        '{ROW_BEAT,       ACT_END,  8'h00, 1'b0, 1'b1, END_OK},
        '{ROW_BEAT,       ACT_CHAR, "T",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "W",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "F",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "u",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "A",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "Z",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "a",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "z",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "0",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "9",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "+",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "/",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_END,  8'hFF, 1'b0, 1'b1, END_OK},
        '{ROW_SET_URL,    ACT_CHAR, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "-",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "_",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "9",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "z",   1'b0, 1'b0, NO_RES},
        '{ROW_SET_PADREQ, ACT_CHAR, 8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "B",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "q",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_END,  8'h5A, 1'b0, 1'b1, END_OK},
        '{ROW_BEAT,       ACT_CHAR, "C",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_CHAR, "D",   1'b0, 1'b0, NO_RES},
        '{ROW_BEAT,       ACT_END,  8'hA5, 1'b0, 1'b1, END_OK}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_beat = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_beat;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // configuration as the decoder should see it
    logic cfg_url = 1'b0;
    logic cfg_padreq = 1'b1;

    // decoder stream state
    logic [1:0]             dec_grp = '0;
    logic [1:0]             dec_pads = '0;
    logic [7:0]             dec_bits = '0;
    logic [OFFSET_BITS-1:0] dec_off = '0;
    logic                   err_seen = 1'b0;
    t_err_kind              err_kind = ERR_NONE;
    logic [OFFSET_BITS-1:0] err_at = '0;

    t_tx_entry   tx_q [$];
    t_tx_entry   held;
    t_out_beat   exp_results [$];
    int unsigned chars_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;

    base64_stream_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // character to 6-bit value under the selected alphabet
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c, input logic url);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a") + 7'd26;
        if (c >= "0" && c <= "9") return 7'(c - "0") + 7'd52;
        if (c == CH_PAD) return 7'd0;
        if (c == (url ? "-" : "+")) return 7'd62;
        if (c == (url ? "_" : "/")) return 7'd63;
        return SYM_BAD;
    endfunction

    // 6-bit value to its character under the selected alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) return "A" + w;
        if (w < 8'd52) return "a" + (w - 8'd26);
        if (w < 8'd62) return "0" + (w - 8'd52);
        if (w == 8'd62) return url ? "-" : "+";
        return url ? "_" : "/";
    endfunction

    function automatic logic [7:0] pick_bad_char(input logic url);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (char_to_sextet(c, url) != SYM_BAD);
        return c;
    endfunction

    function automatic void latch_fault(input t_err_kind k, input logic [OFFSET_BITS-1:0] at);
        err_seen = 1'b1;
        err_kind = k;
        err_at   = at;
    endfunction

    // advance the stream by one beat and return the result it should give
    function automatic t_out_beat decode_beat(input t_in_beat b);
        t_out_beat              r;
        logic [OFFSET_BITS-1:0] here;
        logic [OFFSET_BITS-1:0] back;
        logic [6:0]             sx;
        logic [5:0]             v;
        logic                   is_pad;
        r = '0;
        r.done_res = b.action;
        if (b.action == ACT_CHAR) begin
            here = dec_off;
            back = (here == OFFSET_MAX) ? here
                 : ((here != '0) ? here - OFFSET_BITS'(1) : '0);
            if (dec_off != OFFSET_MAX) dec_off = dec_off + OFFSET_BITS'(1);
            if (!err_seen) begin
                sx = char_to_sextet(b.ch, cfg_url);
                v = sx[5:0];
                is_pad = (b.ch == CH_PAD);
                if (sx == SYM_BAD) begin
                    latch_fault(ERR_BAD_CHAR, here);
                end else if (is_pad && dec_grp < 2'd2) begin
                    latch_fault(ERR_EARLY_PAD, here);
                end else if (!is_pad && dec_pads != 2'd0) begin
                    latch_fault(ERR_DATA_AFTER, back);
                end else if (is_pad && dec_bits != 8'd0) begin
                    latch_fault(ERR_LEFTOVER, back);
                end else begin
                    if (is_pad) dec_pads = dec_pads + 2'd1;
                    case (dec_grp)
                        2'd0: begin
                            dec_bits = {v, 2'b00};
                        end
                        2'd1: begin
                            r.out_byte = dec_bits | {6'd0, v[5:4]};
                            r.byte_valid = 1'b1;
                            dec_bits = {v[3:0], 4'd0};
                        end
                        2'd2: begin
                            r.out_byte = dec_bits | {4'd0, v[5:2]};
                            r.byte_valid = (dec_pads == 2'd0);
                            dec_bits = {v[1:0], 6'd0};
                        end
                        default: begin
                            r.out_byte = dec_bits | {2'd0, v};
                            r.byte_valid = (dec_pads == 2'd0);
                            dec_bits = 8'd0;
                        end
                    endcase
                    dec_grp = dec_grp + 2'd1;
                    if (!r.byte_valid) r.out_byte = 8'd0;
                end
            end
        end else if (!err_seen) begin
            // end of stream rules
            if (cfg_padreq) begin
                if (dec_grp != 2'd0) latch_fault(ERR_INCOMPLETE, dec_off);
            end else if (dec_pads != 2'd0) begin
                latch_fault(ERR_PAD_FORBID, dec_off);
            end
        end
        r.error = err_seen;
        r.error_kind = err_seen ? err_kind : ERR_NONE;
        r.error_offset = err_seen ? err_at : '0;
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // input beats out, result beats checked, output stall picked
    always @(posedge i_clk) begin : beat_flow
        t_out_beat pred;
        t_out_beat want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // input beat taken: predict its result
            if (i_in_valid && !o_in_stall) begin
                pred = decode_beat(i_in_beat);
                exp_results.push_back(held.typed ? held.want : pred);
            end
            // present the next beat or idle
            if (!i_in_valid || !o_in_stall) begin
                if (tx_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held = tx_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_beat <= held.beat;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            // result beat taken: check against the oldest expectation
            if (o_out_valid && !i_out_stall) begin
                if (exp_results.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, got %h",
                             $time, o_out_beat);
                    mismatches++;
                end else begin
                    want = exp_results.pop_front();
                    compare_field("out_byte", 32'(want.out_byte),
                                  32'(o_out_beat.out_byte));
                    compare_field("byte_valid", 32'(want.byte_valid),
                                  32'(o_out_beat.byte_valid));
                    compare_field("error", 32'(want.error), 32'(o_out_beat.error));
                    compare_field("error_kind", 32'(want.error_kind),
                                  32'(o_out_beat.error_kind));
                    compare_field("error_offset", 32'(want.error_offset),
                                  32'(o_out_beat.error_offset));
                    compare_field("done_res", 32'(want.done_res),
                                  32'(o_out_beat.done_res));
                end
            end
        end
        i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[base64_stream_decoder_top] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic action, input logic [7:0] ch, input logic typed,
                             input t_out_beat want);
        t_tx_entry e;
        while (tx_q.size() >= 8) @(negedge i_clk);
        e.beat.action = action;
        e.beat.ch = ch;
        e.typed = typed;
        e.want = want;
        tx_q.push_back(e);
        if (action == ACT_CHAR) chars_sent++;
    endtask

    task automatic send_sym(input logic [5:0] v);
        send_item(ACT_CHAR, sextet_char(v, cfg_url), 1'b0, NO_RES);
    endtask

    task automatic send_end();
        send_item(ACT_END, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // every beat sent has been taken and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tx_q.size() != 0 || i_in_valid || exp_results.size() != 0);
    endtask

    task automatic cfg_write(input logic idx, input logic val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_URL_ALPHABET) cfg_url = val;
        else cfg_padreq = val;
    endtask

    initial begin : stimulus
        t_err_kind fault;
        logic      pad_rule;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < $size(DIRECTED_TAB); i++) begin
            case (DIRECTED_TAB[i].kind)
                ROW_BEAT: begin
                    send_item(DIRECTED_TAB[i].action, DIRECTED_TAB[i].ch,
                              DIRECTED_TAB[i].typed, DIRECTED_TAB[i].want);
                end
                ROW_SET_URL: begin
                    wait_idle();
                    cfg_write(REG_URL_ALPHABET, DIRECTED_TAB[i].cfg_val);
                end
                default: begin
                    wait_idle();
                    cfg_write(REG_PADDING_REQUIRED, DIRECTED_TAB[i].cfg_val);
                end
            endcase
        end

        // well-formed random streams under each setting, one phase without idling
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            cfg_write(REG_URL_ALPHABET, ph == 1 || ph == 2);
            cfg_write(REG_PADDING_REQUIRED, ph < 2);
            steady = (ph == 2);
            repeat (160) begin
                if ((!cfg_padreq || chars_sent[1:0] == 2'd0) && $urandom_range(0, 9) == 0)
                    send_end();
                else
                    send_sym(6'($urandom_range(0, 63)));
            end
            wait_idle();
            steady = 1'b0;
        end

        // closing fault, picked per seed
        fault = t_err_kind'($urandom_range(ERR_BAD_CHAR, ERR_PAD_FORBID));
        case (fault)
            ERR_INCOMPLETE: pad_rule = 1'b1;
            ERR_PAD_FORBID: pad_rule = 1'b0;
            default:        pad_rule = 1'($urandom_range(0, 1));
        endcase
        wait_idle();
        cfg_write(REG_URL_ALPHABET, 1'($urandom_range(0, 1)));
        cfg_write(REG_PADDING_REQUIRED, pad_rule);

        if (fault != ERR_BAD_CHAR && fault != ERR_INCOMPLETE)
            while (chars_sent[1:0] != 2'd0) send_sym(6'($urandom_range(0, 63)));

        case (fault)
            ERR_BAD_CHAR: begin
                send_item(ACT_CHAR, pick_bad_char(cfg_url), 1'b0, NO_RES);
            end
            ERR_EARLY_PAD: begin
                if ($urandom_range(0, 1) == 1) send_sym(6'($urandom_range(0, 63)));
                send_item(ACT_CHAR, CH_PAD, 1'b0, NO_RES);
            end
            ERR_DATA_AFTER, ERR_PAD_FORBID: begin
                // clean padded group: second symbol leaves no stray bits
                send_sym(6'($urandom_range(0, 63)));
                send_sym({2'($urandom_range(0, 3)), 4'h0});
                if ($urandom_range(0, 1) == 1) begin
                    send_item(ACT_CHAR, CH_PAD, 1'b0, NO_RES);
                    send_item(ACT_CHAR, CH_PAD, 1'b0, NO_RES);
                end else begin
                    send_sym({4'($urandom_range(0, 15)), 2'b00});
                    send_item(ACT_CHAR, CH_PAD, 1'b0, NO_RES);
                end
                if (fault == ERR_DATA_AFTER) send_sym(6'($urandom_range(0, 63)));
                else send_end();
            end
            ERR_LEFTOVER: begin
                send_sym(6'($urandom_range(0, 63)));
                if ($urandom_range(0, 1) == 1) begin
                    send_sym({2'($urandom_range(0, 3)), 4'($urandom_range(1, 15))});
                end else begin
                    send_sym(6'($urandom_range(0, 63)));
                    send_sym({4'($urandom_range(0, 15)), 2'($urandom_range(1, 3))});
                end
                send_item(ACT_CHAR, CH_PAD, 1'b0, NO_RES);
            end
            default: begin
                if (chars_sent[1:0] == 2'd0)
                    repeat ($urandom_range(1, 3)) send_sym(6'($urandom_range(0, 63)));
                send_end();
            end
        endcase

        // noise on the latched stream: any byte, repeated ends
        repeat (120) begin
            if ($urandom_range(0, 7) == 0) send_end();
            else send_item(ACT_CHAR, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && exp_results.size() == 0) begin
            $display("[base64_stream_decoder_top] OK");
        end else begin
            $display("[base64_stream_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
